### rtl/knncl_pkg.sv
// knncl_pkg: shared constants, command codes and the control/status structs
// of the k-nearest-neighbour candidate list unit. No dependencies.
`timescale 1ns / 1ps

package knncl_pkg;

  localparam int MAX_K_DEF      = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int NC_BITS        = 4;   // neighbour count register width
  localparam int SIZE_BITS      = 4;   // list_size field width
  localparam int CFG_IDX_BITS   = 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_BOX   = 2'd2,
    OP_READ  = 2'd3
  } knncl_op_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X        = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y        = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEIGHBOR_COUNT = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the accepted item
    logic clear_list;
    logic append;      // write candidate at the end of the list
    logic scan_start;  // reset scan, push candidate into distance pipe
    logic scan_issue;  // read next list entry into distance pipe
    logic resolve;     // compare candidate against farthest
    logic rd_issue;    // read entry for list read-out
    logic rd_next;
    logic out_load;    // load the output register
    logic out_entry;   // output holds a list entry, not a command result
  } knncl_ctl_t;

  // datapath -> controller
  typedef struct packed {
    knncl_op_t op;
    logic      list_full;
    logic      list_empty;
    logic      scan_more;
    logic      pipe_busy;
    logic      rd_last;
  } knncl_stat_t;

endpackage

### rtl/knncl_in_if.sv
// knncl_in_if: input item channel (valid/ready plus command payload).
// Depends on knncl_pkg for the default coordinate width.
`timescale 1ns / 1ps

interface knncl_in_if #(
  parameter int COORD_BITS = knncl_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] box_left;
  logic signed [COORD_BITS-1:0] box_top;
  logic signed [COORD_BITS-1:0] box_right;
  logic signed [COORD_BITS-1:0] box_bottom;

  modport source (
    output valid, cmd, point_x, point_y, box_left, box_top, box_right, box_bottom,
    input  ready
  );
  modport sink (
    input  valid, cmd, point_x, point_y, box_left, box_top, box_right, box_bottom,
    output ready
  );
endinterface

### rtl/knncl_out_if.sv
// knncl_out_if: result item channel (valid/ready plus result payload).
// Depends on knncl_pkg for default widths.
`timescale 1ns / 1ps

interface knncl_out_if #(
  parameter int COORD_BITS = knncl_pkg::COORD_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               stored;
  logic                               box_inside;
  logic                               box_may_improve;
  logic signed [COORD_BITS-1:0]       entry_x;
  logic signed [COORD_BITS-1:0]       entry_y;
  logic                               entry_valid;
  logic [knncl_pkg::SIZE_BITS-1:0]    list_size;
  logic                               last;

  modport source (
    output valid, stored, box_inside, box_may_improve, entry_x, entry_y, entry_valid,
           list_size, last,
    input  ready
  );
  modport sink (
    input  valid, stored, box_inside, box_may_improve, entry_x, entry_y, entry_valid,
           list_size, last,
    output ready
  );
endinterface

### rtl/knncl_ram.sv
// knncl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module knncl_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/knncl_dp.sv
// knncl_dp: datapath - configuration registers, list storage, squared distance
// pipeline with farthest-entry tracking, and the output payload register.
// Depends on knncl_pkg and knncl_ram.
`timescale 1ns / 1ps

module knncl_dp #(
  parameter  int MAX_K      = knncl_pkg::MAX_K_DEF,
  parameter  int COORD_BITS = knncl_pkg::COORD_BITS_DEF,
  localparam int CFG_DW     = (COORD_BITS > knncl_pkg::NC_BITS) ? COORD_BITS
                                                                : knncl_pkg::NC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  knncl_pkg::knncl_ctl_t               ctl,
  output knncl_pkg::knncl_stat_t              stat,
  input  logic                                cfg_we,
  input  logic [knncl_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DW-1:0]                   cfg_data,
  input  logic [1:0]                          in_cmd,
  input  logic signed [COORD_BITS-1:0]        in_point_x,
  input  logic signed [COORD_BITS-1:0]        in_point_y,
  input  logic signed [COORD_BITS-1:0]        in_box_left,
  input  logic signed [COORD_BITS-1:0]        in_box_top,
  input  logic signed [COORD_BITS-1:0]        in_box_right,
  input  logic signed [COORD_BITS-1:0]        in_box_bottom,
  output logic                                res_stored,
  output logic                                res_box_inside,
  output logic                                res_box_may_improve,
  output logic signed [COORD_BITS-1:0]        res_entry_x,
  output logic signed [COORD_BITS-1:0]        res_entry_y,
  output logic                                res_entry_valid,
  output logic [knncl_pkg::SIZE_BITS-1:0]     res_list_size,
  output logic                                res_last
);
  import knncl_pkg::*;

  localparam int IW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CW  = $clog2(MAX_K + 1);
  localparam int KW  = (CW > NC_BITS) ? CW : NC_BITS;
  localparam int DXW = COORD_BITS + 1;
  localparam int SQW = 2 * COORD_BITS + 1;
  localparam int DW  = 2 * COORD_BITS + 2;
  localparam int EW  = 2 * COORD_BITS;

  function automatic logic signed [COORD_BITS-1:0] nearest_axis(
    input logic signed [COORD_BITS-1:0] q,
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi
  );
    logic signed [COORD_BITS-1:0] r;
    if (q > hi) begin
      r = hi;
    end else if (q >= lo) begin
      r = q;
    end else begin
      r = lo;
    end
    return r;
  endfunction

  // configuration
  logic signed [COORD_BITS-1:0] qx_r, qy_r;
  logic [NC_BITS-1:0]           nc_r;

  // item and list state
  knncl_op_t                    op_r;
  logic signed [COORD_BITS-1:0] cand_x_r, cand_y_r;
  logic                         inside_r, stored_res_r, improve_res_r;
  logic [CW-1:0]                kept_r, scan_idx_r, limit_r, rd_idx_r;
  logic [DW-1:0]                best_d_r, cand_d_r;
  logic [IW-1:0]                best_idx_r;

  // distance pipe
  logic                         v1_r, c1_r, v2_r, c2_r, v3_r, c3_r, v4_r, c4_r;
  logic [IW-1:0]                i1_r, i2_r, i3_r, i4_r;
  logic signed [DXW-1:0]        dx2_r, dy2_r;
  logic [SQW-1:0]               sqx3_r, sqy3_r;
  logic [DW-1:0]                d4_r;

  logic [KW-1:0]                nc_w, k_w;
  logic [CW-1:0]                k_eff;
  logic signed [COORD_BITS-1:0] x1, y1, nb_x, nb_y;
  logic signed [2*DXW-1:0]      prod_x, prod_y;
  logic                         box_in, closer, ram_we, ram_re;
  logic [IW-1:0]                ram_waddr, ram_raddr;
  logic [EW-1:0]                ram_q;
  knncl_op_t                    in_op;

  // k clamped to 1..MAX_K
  always_comb begin
    nc_w = KW'(nc_r);
    if (nc_r == '0) begin
      k_w = KW'(1);
    end else if (nc_w > KW'(MAX_K)) begin
      k_w = KW'(MAX_K);
    end else begin
      k_w = nc_w;
    end
    k_eff = k_w[CW-1:0];
  end

  assign in_op  = knncl_op_t'(in_cmd);
  assign nb_x   = nearest_axis(qx_r, in_box_left, in_box_right);
  assign nb_y   = nearest_axis(qy_r, in_box_top, in_box_bottom);
  assign box_in = (qx_r >= in_box_left) && (qy_r >= in_box_top) &&
                  (qx_r <= in_box_right) && (qy_r <= in_box_bottom);
  assign closer = cand_d_r < best_d_r;

  assign x1     = c1_r ? cand_x_r : ram_q[EW-1:COORD_BITS];
  assign y1     = c1_r ? cand_y_r : ram_q[COORD_BITS-1:0];
  assign prod_x = dx2_r * dx2_r;
  assign prod_y = dy2_r * dy2_r;

  assign ram_we    = ctl.append || (ctl.resolve && (op_r == OP_OFFER) && closer);
  assign ram_waddr = ctl.append ? kept_r[IW-1:0] : best_idx_r;
  assign ram_re    = ctl.scan_issue || ctl.rd_issue;
  assign ram_raddr = ctl.rd_issue ? rd_idx_r[IW-1:0] : scan_idx_r[IW-1:0];

  knncl_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_K)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cand_x_r, cand_y_r}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_comb begin
    stat.op         = op_r;
    stat.list_full  = kept_r >= k_eff;
    stat.list_empty = kept_r == '0;
    stat.scan_more  = scan_idx_r < limit_r;
    stat.pipe_busy  = v1_r || v2_r || v3_r || v4_r;
    stat.rd_last    = (rd_idx_r + CW'(1)) == kept_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r   <= '0;
      qy_r   <= '0;
      nc_r   <= NC_BITS'(1);
      kept_r <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_QUERY_X:        qx_r <= cfg_data[COORD_BITS-1:0];
          CFG_QUERY_Y:        qy_r <= cfg_data[COORD_BITS-1:0];
          CFG_NEIGHBOR_COUNT: nc_r <= cfg_data[NC_BITS-1:0];
          default: ;
        endcase
      end
      if (ctl.clear_list) begin
        kept_r <= '0;
      end else if (ctl.append) begin
        kept_r <= kept_r + CW'(1);
      end
      v1_r <= ctl.scan_start || ctl.scan_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r          <= in_op;
      cand_x_r      <= (in_op == OP_BOX) ? nb_x : in_point_x;
      cand_y_r      <= (in_op == OP_BOX) ? nb_y : in_point_y;
      inside_r      <= (in_op == OP_BOX) && box_in;
      stored_res_r  <= 1'b0;
      improve_res_r <= 1'b0;
      rd_idx_r      <= '0;
    end
    if (ctl.append) begin
      stored_res_r <= 1'b1;
    end
    if (ctl.scan_start) begin
      scan_idx_r <= '0;
      limit_r    <= (op_r == OP_OFFER) ? k_eff : kept_r;
      best_d_r   <= '0;
      best_idx_r <= '0;
    end else if (ctl.scan_issue) begin
      scan_idx_r <= scan_idx_r + CW'(1);
    end
    if (ctl.resolve) begin
      if (op_r == OP_OFFER) begin
        stored_res_r <= closer;
      end else begin
        improve_res_r <= closer;
      end
    end
    if (ctl.rd_next) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end

    // distance pipe: difference, squares, sum, farthest update
    c1_r   <= ctl.scan_start;
    i1_r   <= scan_idx_r[IW-1:0];
    dx2_r  <= DXW'(x1) - DXW'(qx_r);
    dy2_r  <= DXW'(y1) - DXW'(qy_r);
    c2_r   <= c1_r;
    i2_r   <= i1_r;
    sqx3_r <= prod_x[SQW-1:0];
    sqy3_r <= prod_y[SQW-1:0];
    c3_r   <= c2_r;
    i3_r   <= i2_r;
    d4_r   <= DW'(sqx3_r) + DW'(sqy3_r);
    c4_r   <= c3_r;
    i4_r   <= i3_r;
    if (v4_r) begin
      if (c4_r) begin
        cand_d_r <= d4_r;
      end else if (best_d_r <= d4_r) begin
        // ties: the later entry counts as farthest
        best_d_r   <= d4_r;
        best_idx_r <= i4_r;
      end
    end

    if (ctl.out_load) begin
      res_list_size <= SIZE_BITS'(kept_r);
      if (ctl.out_entry) begin
        res_stored          <= 1'b0;
        res_box_inside      <= 1'b0;
        res_box_may_improve <= 1'b0;
        res_entry_x         <= ram_q[EW-1:COORD_BITS];
        res_entry_y         <= ram_q[COORD_BITS-1:0];
        res_entry_valid     <= 1'b1;
        res_last            <= stat.rd_last;
      end else begin
        res_stored          <= stored_res_r;
        res_box_inside      <= inside_r;
        res_box_may_improve <= improve_res_r;
        res_entry_x         <= '0;
        res_entry_y         <= '0;
        res_entry_valid     <= 1'b0;
        res_last            <= 1'b1;
      end
    end
  end

endmodule

### rtl/knncl_ctrl.sv
// knncl_ctrl: sequencing state machine for the candidate list unit; drives
// the datapath commands and the channel handshakes. Depends on knncl_pkg.
`timescale 1ns / 1ps

module knncl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output knncl_pkg::knncl_ctl_t  ctl,
  input  knncl_pkg::knncl_stat_t stat
);
  import knncl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (stat.op)
          OP_CLEAR: begin
            ctl.clear_list = 1'b1;
            state_nxt      = ST_EMIT;
          end
          OP_OFFER: begin
            if (!stat.list_full) begin
              ctl.append = 1'b1;
              state_nxt  = ST_EMIT;
            end else begin
              ctl.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          OP_BOX: begin
            ctl.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
          OP_READ: begin
            state_nxt = stat.list_empty ? ST_EMIT : ST_RD_ADDR;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (stat.scan_more) begin
          ctl.scan_issue = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          ctl.resolve = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        ctl.rd_issue = 1'b1;
        state_nxt    = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (out_free) begin
          ctl.out_load  = 1'b1;
          ctl.out_entry = 1'b1;
          ctl.rd_next   = 1'b1;
          state_nxt     = stat.rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/knn_candidate_list_unit.sv
// knn_candidate_list_unit: top level of the k-nearest-neighbour candidate
// list. Depends on knncl_pkg, knncl_in_if, knncl_out_if, knncl_ctrl, knncl_dp.
//
//   channel  direction  handshake        payload
//   in_ch    sink       valid/ready      cmd, point_x/y, box_left/top/right/bottom
//   out_ch   source     valid/ready      stored, box_inside, box_may_improve,
//                                        entry_x/y, entry_valid, list_size, last
//   cfg_*    write      cfg_we           cfg_idx selects register, cfg_data value
//
// One item at a time. Clear, empty read or an offer to a non-full list: no list scan.
// Offer to a full list or box test: n entries, n = k or the kept count, go through
// the one-entry-per-cycle scan through the list RAM read port followed
// by the four-stage squared-distance pipeline. Read list: RD_ADDR then RD_DATA per entry.
// Reset empties the list, query = 0, k = 1; the list RAM needs no clearing pass.
// A finished result waits in the output register while the next item is taken;
// with out_ch.ready low the following result stalls the unit.
`timescale 1ns / 1ps

module knn_candidate_list_unit #(
  parameter  int MAX_K      = knncl_pkg::MAX_K_DEF,
  parameter  int COORD_BITS = knncl_pkg::COORD_BITS_DEF,
  localparam int CFG_DW     = (COORD_BITS > knncl_pkg::NC_BITS) ? COORD_BITS
                                                                : knncl_pkg::NC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  knncl_in_if.sink                           in_ch,
  knncl_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [knncl_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_DW-1:0]                  cfg_data
);
  import knncl_pkg::*;

  knncl_ctl_t  ctl;
  knncl_stat_t stat;

  knncl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  knncl_dp #(
    .MAX_K      (MAX_K),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_data            (cfg_data),
    .in_cmd              (in_ch.cmd),
    .in_point_x          (in_ch.point_x),
    .in_point_y          (in_ch.point_y),
    .in_box_left         (in_ch.box_left),
    .in_box_top          (in_ch.box_top),
    .in_box_right        (in_ch.box_right),
    .in_box_bottom       (in_ch.box_bottom),
    .res_stored          (out_ch.stored),
    .res_box_inside      (out_ch.box_inside),
    .res_box_may_improve (out_ch.box_may_improve),
    .res_entry_x         (out_ch.entry_x),
    .res_entry_y         (out_ch.entry_y),
    .res_entry_valid     (out_ch.entry_valid),
    .res_list_size       (out_ch.list_size),
    .res_last            (out_ch.last)
  );

  // only one item is worked on at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous item still in progress");

  // only a list read gives more than one result per item
  a_multi_is_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> out_ch.entry_valid)
    else $error("non-final result that is not a list entry");

  // list entries carry no command flags
  a_entry_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.entry_valid) |->
      (!out_ch.stored && !out_ch.box_inside && !out_ch.box_may_improve))
    else $error("list entry result with command flags set");

  // offer and box test results are exclusive
  a_stored_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stored) |-> (!out_ch.box_inside && !out_ch.box_may_improve))
    else $error("stored flag together with box flags");

endmodule
